// ===== rtl/nst_pkg.sv =====
`default_nettype none

package nst_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_NAME_BYTES  = 8;
   localparam int DEF_COUNT_BITS  = 16;

   typedef enum logic [1:0] {
      KIND_OPEN,
      KIND_WAIT,
      KIND_POST,
      KIND_UNLINK
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NOT_FOUND,
      ST_WOULD_BLOCK,
      ST_FULL,
      ST_BAD_HANDLE
   } status_type;

   typedef struct packed {
      kind_type     kind;
      logic [63:0]  sem_name;
      logic [15:0]  init_value;
      logic [3:0]   handle;
   } req_type;

   typedef struct packed {
      status_type   status;
      logic [3:0]   slot;
      logic [15:0]  count;
      logic         created;
      logic         wake;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/nst_name_clean.sv =====
`default_nettype none

module nst_name_clean #(
   parameter int NAME_BYTES = nst_pkg::DEF_NAME_BYTES
) (
   input  wire logic [63:0]             raw_name,
   output logic      [8*NAME_BYTES-1:0] clean_name
);

   logic alive;

   // A name ends at its first zero byte; everything after it reads as zero.
   always_comb begin
      alive = 1'b1;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (raw_name[8*b +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         clean_name[8*b +: 8] = alive ? raw_name[8*b +: 8] : 8'd0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/named_semaphore_table.sv =====
// Named counting semaphore table.
//
// Requests arrive on the req_ channel (valid/stall) as one beat holding an
// operation kind, a name, an initial count and a handle. Every request gives
// exactly one response beat on the rsp_ channel, in request order.
//
// Names and counts live in two synchronous single-port-read memories. Open
// and unlink scan the live slots one per cycle through the name memory.
// Wait and post do one read-modify-write of the count memory; a bad handle
// answers without touching the memories. One request is in flight at a
// time: req_stall is high from acceptance until the response has been
// loaded into the output register.
//
// The response sits in an output register, so a new request is accepted
// while an earlier response is still stalled by the receiver; the finished
// result of that new request then waits until the output register frees.
// Synchronous reset empties the table and drops any pending response; the
// memories need no clearing pass.
`default_nettype none

module named_semaphore_table #(
   parameter int TABLE_DEPTH = nst_pkg::DEF_TABLE_DEPTH,
   parameter int NAME_BYTES  = nst_pkg::DEF_NAME_BYTES,
   parameter int COUNT_BITS  = nst_pkg::DEF_COUNT_BITS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire nst_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output nst_pkg::rsp_type     rsp_payload
);

   import nst_pkg::*;

   localparam int NAME_BITS = 8 * NAME_BYTES;
   localparam int USED_W    = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CMP_W     = (USED_W > 4) ? USED_W : 4;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [USED_W-1:0]     used_type;
   typedef logic [COUNT_BITS-1:0] cnt_type;
   typedef logic [NAME_BITS-1:0]  name_type;

   typedef struct packed {
      logic    waiting;
      cnt_type count;
   } ent_type;

   localparam cnt_type CNT_MAX = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_OPEN_READ,
      S_UNL_READ,
      S_UNL_WRITE,
      S_RMW,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   kind_type  op_ff, op_in;
   name_type  name_ff, name_in;
   cnt_type   init_ff, init_in;
   logic [3:0] handle_ff, handle_in;
   used_type  used_ff, used_in;
   used_type  issue_ff, issue_in;
   logic      cmp_valid_ff, cmp_valid_in;
   idx_type   cmp_idx_ff, cmp_idx_in;
   idx_type   at_ff, at_in;
   cnt_type   old_ff, old_in;
   name_type  last_name_ff, last_name_in;
   rsp_type   res_ff, res_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   name_type  name_mem [TABLE_DEPTH];
   ent_type   data_mem [TABLE_DEPTH];
   name_type  name_rd_ff;
   ent_type   data_rd_ff;

   logic      name_we, data_we;
   idx_type   name_raddr, name_waddr, data_raddr, data_waddr;
   name_type  name_wdata;
   ent_type   data_wdata;

   name_type  req_name_clean;
   logic [31:0] init_wide;
   idx_type   last_idx;
   logic      accept;

   nst_name_clean #(
      .NAME_BYTES (NAME_BYTES)
   ) u_name_clean (
      .raw_name   (req_payload.sem_name),
      .clean_name (req_name_clean)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign init_wide = 32'(req_payload.init_value);
   assign last_idx  = idx_type'(used_ff - used_type'(1));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      name_in      = name_ff;
      init_in      = init_ff;
      handle_in    = handle_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      at_in        = at_ff;
      old_in       = old_ff;
      last_name_in = last_name_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      name_we      = 1'b0;
      name_waddr   = '0;
      name_wdata   = name_ff;
      name_raddr   = '0;
      data_we      = 1'b0;
      data_waddr   = '0;
      data_wdata   = data_rd_ff;
      data_raddr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_payload.kind;
               name_in   = req_name_clean;
               handle_in = req_payload.handle;
               issue_in  = '0;
               if (init_wide > 32'(CNT_MAX)) begin
                  init_in = CNT_MAX;
               end else begin
                  init_in = cnt_type'(req_payload.init_value);
               end
               unique case (req_payload.kind)
                  KIND_OPEN, KIND_UNLINK: begin
                     state_in = S_SCAN;
                  end
                  KIND_WAIT, KIND_POST: begin
                     if (CMP_W'(req_payload.handle) >= CMP_W'(used_ff)) begin
                        res_in        = '0;
                        res_in.status = ST_BAD_HANDLE;
                        res_in.slot   = req_payload.handle;
                        state_in      = S_RESP;
                     end else begin
                        data_raddr = idx_type'(req_payload.handle);
                        state_in   = S_RMW;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cmp_valid_ff && name_rd_ff == name_ff) begin
               at_in      = cmp_idx_ff;
               data_raddr = cmp_idx_ff;
               name_raddr = last_idx;
               state_in   = (op_ff == KIND_OPEN) ? S_OPEN_READ : S_UNL_READ;
            end else if (issue_ff < used_ff) begin
               name_raddr   = idx_type'(issue_ff);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_type'(issue_ff);
               issue_in     = issue_ff + used_type'(1);
            end else if (!cmp_valid_ff) begin
               res_in   = '0;
               state_in = S_RESP;
               if (op_ff != KIND_OPEN) begin
                  res_in.status = ST_NOT_FOUND;
               end else if (used_ff == used_type'(TABLE_DEPTH)) begin
                  res_in.status = ST_FULL;
               end else begin
                  name_we            = 1'b1;
                  name_waddr         = idx_type'(used_ff);
                  name_wdata         = name_ff;
                  data_we            = 1'b1;
                  data_waddr         = idx_type'(used_ff);
                  data_wdata.waiting = 1'b0;
                  data_wdata.count   = init_ff;
                  used_in            = used_ff + used_type'(1);
                  res_in.status      = ST_OK;
                  res_in.slot        = 4'(used_ff);
                  res_in.count       = 16'(init_ff);
                  res_in.created     = 1'b1;
               end
            end
         end
         S_OPEN_READ: begin
            res_in        = '0;
            res_in.status = ST_OK;
            res_in.slot   = 4'(at_ff);
            res_in.count  = 16'(data_rd_ff.count);
            state_in      = S_RESP;
         end
         S_UNL_READ: begin
            old_in       = data_rd_ff.count;
            last_name_in = name_rd_ff;
            data_raddr   = last_idx;
            state_in     = S_UNL_WRITE;
         end
         S_UNL_WRITE: begin
            name_we       = 1'b1;
            name_waddr    = at_ff;
            name_wdata    = last_name_ff;
            data_we       = 1'b1;
            data_waddr    = at_ff;
            data_wdata    = data_rd_ff;
            used_in       = used_ff - used_type'(1);
            res_in        = '0;
            res_in.status = ST_OK;
            res_in.slot   = 4'(at_ff);
            res_in.count  = 16'(old_ff);
            state_in      = S_RESP;
         end
         S_RMW: begin
            data_we     = 1'b1;
            data_waddr  = idx_type'(handle_ff);
            res_in      = '0;
            res_in.slot = handle_ff;
            state_in    = S_RESP;
            if (op_ff == KIND_WAIT) begin
               if (data_rd_ff.count != '0) begin
                  data_wdata.waiting = data_rd_ff.waiting;
                  data_wdata.count   = data_rd_ff.count - cnt_type'(1);
                  res_in.status      = ST_OK;
                  res_in.count       = 16'(data_rd_ff.count - cnt_type'(1));
               end else begin
                  data_wdata.waiting = 1'b1;
                  data_wdata.count   = data_rd_ff.count;
                  res_in.status      = ST_WOULD_BLOCK;
               end
            end else begin
               data_wdata.waiting = 1'b0;
               if (data_rd_ff.count != CNT_MAX) begin
                  data_wdata.count = data_rd_ff.count + cnt_type'(1);
               end else begin
                  data_wdata.count = data_rd_ff.count;
               end
               res_in.status = ST_OK;
               res_in.count  = 16'(data_wdata.count);
               res_in.wake   = data_rd_ff.waiting;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      name_ff      <= name_in;
      init_ff      <= init_in;
      handle_ff    <= handle_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      at_ff        <= at_in;
      old_ff       <= old_in;
      last_name_ff <= last_name_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[name_waddr] <= name_wdata;
      end
      name_rd_ff <= name_mem[name_raddr];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_rd_ff <= data_mem[data_raddr];
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= used_type'(TABLE_DEPTH))
      else $error("Live entry count exceeds the table depth.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("Accepted request did not start an operation.");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("Response beat appeared outside the response state.");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("Finished operation did not load a response beat.");

endmodule

`default_nettype wire
